### sv/ps2fr_pkg.sv
// Shared types and constants for the PS/2 frame receiver with scan-code FIFO.
package ps2fr_pkg;

    // Default number of ring slots (holds one less byte than this)
    localparam int RING_DEPTH_DEF = 16;

    // Reset value of the idle gap limit in ms
    localparam logic [15:0] GAP_RESET = 16'd250;

    // Bits in one device-to-host frame
    localparam logic [3:0] FRAME_BITS = 4'd11;

    // Position of the last data bit within the byte
    localparam logic [2:0] LAST_DATA_POS = 3'd7;

    // Beat kinds carried in the slave tuser bit
    typedef enum logic
    {
        ACT_EDGE = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    // Frame assembler report for the beat being committed
    typedef struct packed
    {
        logic       done;
        logic [7:0] code;
    } frame_stat_t;

    // Ring occupancy seen by the beat being committed
    typedef struct packed
    {
        logic full;
        logic empty;
    } ring_stat_t;

endpackage

### sv/ps2fr_frame.sv
// Gap check and bit assembly of PS/2 frames, with the gap limit register.
module ps2fr_frame
    import ps2fr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        edge_go,
    input  logic        data_bit,
    input  logic [31:0] now_ms,
    output frame_stat_t frame_stat
);

    logic [15:0] gap_limit_reg;
    logic [3:0]  bit_index_reg;
    logic [3:0]  bit_index_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic [31:0] last_ms_reg;

    logic [31:0] elapsed;
    logic        gap_hit;
    logic [3:0]  bit_pos;
    logic [3:0]  bit_inc;
    logic [7:0]  byte_work;
    logic [2:0]  data_pos;

    // Clear a partial frame after a long idle gap, then place the data bit
    always_comb
    begin
        elapsed   = now_ms - last_ms_reg;
        gap_hit   = elapsed > {16'd0, gap_limit_reg};
        bit_pos   = gap_hit ? 4'd0 : bit_index_reg;
        byte_work = gap_hit ? 8'd0 : byte_reg;
        data_pos  = 3'(bit_pos - 4'd1);
        if (bit_pos >= 4'd1 && bit_pos <= {1'b0, LAST_DATA_POS} + 4'd1)
        begin
            byte_work[data_pos] = data_bit;
        end
        bit_inc         = bit_pos + 4'd1;
        frame_stat.done = bit_inc == FRAME_BITS;
        frame_stat.code = byte_work;
        bit_index_next  = frame_stat.done ? 4'd0 : bit_inc;
        byte_next       = frame_stat.done ? 8'd0 : byte_work;
    end

    // Hold receiver state; advance on each committed edge beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= GAP_RESET;
            bit_index_reg <= 4'd0;
            byte_reg      <= 8'd0;
            last_ms_reg   <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                gap_limit_reg <= cfg_wdata;
            end
            if (edge_go)
            begin
                bit_index_reg <= bit_index_next;
                byte_reg      <= byte_next;
                last_ms_reg   <= now_ms;
            end
        end
    end

endmodule

### sv/ps2fr_ring.sv
// Ring buffer of scan codes with registered read data.
module ps2fr_ring
    import ps2fr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  logic       push,
    input  logic       pop,
    input  logic [7:0] wr_data,
    output ring_stat_t ring_stat,
    output logic [7:0] rd_data_reg
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

    logic [7:0]       mem [RING_DEPTH];
    logic [PTR_W-1:0] wr_idx_reg;
    logic [PTR_W-1:0] rd_idx_reg;
    logic [PTR_W-1:0] wr_step;
    logic [PTR_W-1:0] rd_step;
    logic             push_ok;
    logic             pop_ok;

    // Step both pointers with wrap at the last slot
    always_comb
    begin
        wr_step         = (wr_idx_reg == LAST_SLOT) ? '0 : wr_idx_reg + 1'b1;
        rd_step         = (rd_idx_reg == LAST_SLOT) ? '0 : rd_idx_reg + 1'b1;
        ring_stat.empty = rd_idx_reg == wr_idx_reg;
        ring_stat.full  = wr_step == rd_idx_reg;
        push_ok         = go && push && !ring_stat.full;
        pop_ok          = go && pop && !ring_stat.empty;
    end

    // Advance pointers on a stored push or a served pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_idx_reg <= wr_step;
            end
            if (pop_ok)
            begin
                rd_idx_reg <= rd_step;
            end
        end
    end

    // Write the slot after the last written; read the slot after the last read
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_step] <= wr_data;
        end
        if (go)
        begin
            rd_data_reg <= pop_ok ? mem[rd_step] : 8'd0;
        end
    end

endmodule

### sv/ps2fr_ps2_frame_receiver_fifo.sv
// Result register: master valid and status flags for each committed beat.
module ps2fr_out_reg
    import ps2fr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic go,
    input  logic m_tready,
    input  logic is_pop,
    input  logic frame_done,
    input  ring_stat_t ring_stat,
    output logic m_tvalid_reg,
    output logic empty_reg,
    output logic stored_reg,
    output logic dropped_reg
);

    // Load result flags on a committed beat; drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (go)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            empty_reg   <= is_pop && ring_stat.empty;
            stored_reg  <= !is_pop && frame_done && !ring_stat.full;
            dropped_reg <= !is_pop && frame_done && ring_stat.full;
        end
    end

endmodule

### sv/ps2_frame_receiver_fifo.sv
// Top level: PS/2 frame receiver feeding a scan-code ring FIFO.
// A beat accepted into the input register is committed once the result register
// is free or being drained; its result then shows on the master side from there.
// Throughput: one beat per cycle while the master side does not stall; each beat
// passes input register, one pass of gap/assembly or ring logic, and the result register (ring read is registered).
// Reset (rst_n low, async): gap limit 250 ms, frame state, timestamp and ring
// pointers cleared, both registers empty; ring contents are not cleared.
module ps2_frame_receiver_fifo
    import ps2fr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [0] data_bit, [32:1] now_ms, [39:33] zero
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] scan_code, [8] fifo_empty,
                                   // [9] frame_stored, [10] frame_dropped, zero
);

    logic        in_valid_reg;
    action_t     in_action_reg;
    logic        in_bit_reg;
    logic [31:0] in_now_reg;
    logic        go;
    logic        is_pop;
    logic        s_hs;

    frame_stat_t frame_stat;
    ring_stat_t  ring_stat;
    logic [7:0]  code_reg;
    logic        m_tvalid_reg;
    logic        empty_reg;
    logic        stored_reg;
    logic        dropped_reg;

    // Commit the held beat when the result register is free or being drained
    assign go       = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || go;
    assign s_hs     = s_tvalid && s_tready;
    assign is_pop   = in_action_reg == ACT_POP;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_hs)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_hs)
        begin
            in_action_reg <= action_t'(s_tuser);
            in_bit_reg    <= s_tdata[0];
            in_now_reg    <= s_tdata[32:1];
        end
    end

    ps2fr_frame u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .edge_go    (go && !is_pop),
        .data_bit   (in_bit_reg),
        .now_ms     (in_now_reg),
        .frame_stat (frame_stat)
    );

    ps2fr_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .push        (!is_pop && frame_stat.done),
        .pop         (is_pop),
        .wr_data     (frame_stat.code),
        .ring_stat   (ring_stat),
        .rd_data_reg (code_reg)
    );

    ps2fr_out_reg u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .m_tready     (m_tready),
        .is_pop       (is_pop),
        .frame_done   (frame_stat.done),
        .ring_stat    (ring_stat),
        .m_tvalid_reg (m_tvalid_reg),
        .empty_reg    (empty_reg),
        .stored_reg   (stored_reg),
        .dropped_reg  (dropped_reg)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, dropped_reg, stored_reg, empty_reg, code_reg};

    // At most one status flag per result beat
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tdata[10:8]))
        else $error("more than one status flag set");

    // An empty pop or a stored or dropped frame result carries a zero code
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[8] || m_tdata[9] || m_tdata[10]) |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero code on flag result");

    // Backpressure only while both registers hold beats
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && m_tvalid_reg && !m_tready)
        else $error("input stalled without a full pipeline");

    // A stored frame leaves the ring nonempty
    a_store_fills: assert property (@(posedge clk) disable iff (!rst_n)
        go && !is_pop && frame_stat.done && !ring_stat.full |=> !ring_stat.empty)
        else $error("ring empty after a stored frame");

endmodule

### sim/ps2_frame_receiver_fifo_tb.sv
// Self-checking testbench for the PS/2 frame receiver with scan-code ring FIFO.
module ps2_frame_receiver_fifo_tb;
    import ps2fr_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // Sender and receiver idling patterns
    typedef enum int
    {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    // One slave beat: edge with data bit and timestamp, or pop
    typedef struct
    {
        action_t     act;
        logic        data_bit;
        logic [31:0] now_ms;
    } ps2_beat_t;

    // Master beat fields, lowest bit first: scan_code, fifo_empty, stored, dropped
    typedef struct packed
    {
        logic       dropped;
        logic       stored;
        logic       empty;
        logic [7:0] code;
    } scan_report_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = 40'd0;   // [0] data_bit, [32:1] now_ms, [39:33] zero
    logic        s_tuser = 1'b0;    // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] scan_code, [8] fifo_empty,
                                    // [9] frame_stored, [10] frame_dropped, zero

    // Receiver state mirror
    logic [15:0] gap_ms = GAP_RESET;
    logic [3:0]  bit_pos = 4'd0;
    logic [7:0]  shift_byte = 8'd0;
    logic [31:0] last_ms = 32'd0;
    int          wr_slot = 0;
    int          rd_slot = 0;
    logic [7:0]  code_ring[DEPTH];

    // Stimulus and scoreboard
    ps2_beat_t    beat_q[$];
    scan_report_t report_q[$];
    logic [31:0]  gen_ms = 32'd0;
    int           beats_made = 0;
    int           fail_count = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    logic         s_took = 1'b0;

    ps2_frame_receiver_fifo uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Advance the receiver mirror by one beat and return its report
    function automatic scan_report_t receive_beat(action_t act, logic data_bit,
                                                  logic [31:0] now_ms);
        scan_report_t rep;
        logic [31:0]  idle_ms;
        int           slot;
        rep = '0;
        if (act == ACT_EDGE)
        begin
            idle_ms = now_ms - last_ms;
            if (idle_ms > {16'd0, gap_ms})
            begin
                bit_pos = 4'd0;
                shift_byte = 8'd0;
            end
            last_ms = now_ms;
            if (bit_pos >= 4'd1 && (bit_pos - 4'd1) <= {1'b0, LAST_DATA_POS} && data_bit)
                shift_byte[bit_pos - 4'd1] = 1'b1;
            bit_pos = bit_pos + 4'd1;
            if (bit_pos == FRAME_BITS)
            begin
                slot = (wr_slot + 1) % DEPTH;
                if (slot != rd_slot)
                begin
                    code_ring[slot] = shift_byte;
                    wr_slot = slot;
                    rep.stored = 1'b1;
                end
                else
                begin
                    rep.dropped = 1'b1;
                end
                bit_pos = 4'd0;
                shift_byte = 8'd0;
            end
        end
        else
        begin
            if (rd_slot == wr_slot)
            begin
                rep.empty = 1'b1;
            end
            else
            begin
                rd_slot = (rd_slot + 1) % DEPTH;
                rep.code = code_ring[rd_slot];
            end
        end
        return rep;
    endfunction

    // Eleven line levels of a frame, start bit first, odd parity
    function automatic logic [10:0] frame_levels(logic [7:0] code);
        return {1'b1, ~^code, code, 1'b0};
    endfunction

    task automatic add_edge(input logic data_bit, input logic [31:0] now_ms);
        ps2_beat_t b;
        b.act = ACT_EDGE;
        b.data_bit = data_bit;
        b.now_ms = now_ms;
        gen_ms = now_ms;
        beat_q.push_back(b);
        beats_made++;
    endtask

    task automatic add_pop();
        ps2_beat_t b;
        b.act = ACT_POP;
        b.data_bit = 1'($urandom_range(1));
        b.now_ms = $urandom();
        beat_q.push_back(b);
        beats_made++;
    endtask

    // Queue a frame; optionally open with an idle gap and use the exact limit as step
    task automatic add_frame(input logic [7:0] code, input int n_edges,
                             input logic clear_first, input logic exact_step);
        logic [10:0] levels;
        logic [31:0] step;
        levels = frame_levels(code);
        // Corrupt the framing bits now and then; they go unchecked
        if ($urandom_range(99) < 15)
        begin
            levels[0] = 1'($urandom_range(1));
            levels[9] = 1'($urandom_range(1));
            levels[10] = 1'($urandom_range(1));
        end
        for (int i = 0; i < n_edges; i++)
        begin
            if (i == 0 && clear_first)
                step = {16'd0, gap_ms} + 32'd1 + $urandom_range(3);
            else if (exact_step || $urandom_range(99) < 20)
                step = {16'd0, gap_ms};
            else
                step = $urandom_range(gap_ms);
            add_edge(levels[i], gen_ms + step);
        end
    endtask

    // Queue roughly n beats: mostly frames, with pop bursts and stray edges
    task automatic fill_random(input int n, input int pop_pct);
        int goal;
        int pick;
        int sel;
        logic [31:0] step;
        goal = beats_made + n;
        while (beats_made < goal)
        begin
            pick = $urandom_range(99);
            if (pick < pop_pct)
            begin
                sel = $urandom_range(1, 4);
                repeat (sel) add_pop();
            end
            else if (pick < pop_pct + 10)
            begin
                sel = $urandom_range(3);
                case (sel)
                    0: step = {16'd0, gap_ms} + 32'd1;
                    1: step = $urandom();
                    2: step = {16'd0, gap_ms};
                    default: step = 32'd0;
                endcase
                add_edge(1'($urandom_range(1)), gen_ms + step);
            end
            else
            begin
                sel = ($urandom_range(99) < 10) ? $urandom_range(1, 10) : 11;
                add_frame(8'($urandom()), sel, $urandom_range(99) < 70, 1'b0);
            end
        end
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 87; stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 87; end
            IDLE_BOTH: begin send_idle_pct = 31; stall_pct = 31; end
            default:   begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Hold until every queued beat is sent and every report has arrived
    task automatic wait_drained();
        do
            @(posedge clk);
        while (beat_q.size() != 0 || s_tvalid || report_q.size() != 0);
    endtask

    task automatic write_gap_limit(input logic [15:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        gap_ms = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drive slave beats and master backpressure on the falling edge
    always @(negedge clk)
    begin : drive
        ps2_beat_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || s_took)
            begin
                if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt.act;
                    s_tdata <= {7'd0, nxt.now_ms, nxt.data_bit};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Predict on accepted slave beats, check accepted master beats
    always @(posedge clk)
    begin : watch
        scan_report_t got;
        scan_report_t want;
        if (!rst_n)
        begin
            s_took <= 1'b0;
        end
        else
        begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                report_q.push_back(receive_beat(action_t'(s_tuser), s_tdata[0],
                                                s_tdata[32:1]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[10:0];
                if (report_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected beat: code %h empty %b stored %b dropped %b",
                                 got.code, got.empty, got.stored, got.dropped);
                    fail_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (got.code !== want.code || got.empty !== want.empty ||
                        got.stored !== want.stored || got.dropped !== want.dropped)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display({"wrong beat: expected code %h empty %b stored %b",
                                      " dropped %b, got code %h empty %b stored %b",
                                      " dropped %b"},
                                     want.code, want.empty, want.stored, want.dropped,
                                     got.code, got.empty, got.stored, got.dropped);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ps2_frame_receiver_fifo: mismatch");
            $finish;
        end
    end

    initial
    begin : main
        logic [15:0] limits[5];
        int          counts[5];
        int          pops[5];
        logic [10:0] levels;
        limits = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 600)), GAP_RESET,
                   16'($urandom())};
        counts = '{200, 110, 110, 110, 100};
        pops = '{3, 40, 15, 30, 20};

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty pop, frame stepped at exactly the gap limit, pop it,
        // partial frame cut by a gap, all-ones frame across the timestamp wrap
        set_idling(IDLE_NONE);
        add_pop();
        add_frame(8'hA5, 11, 1'b0, 1'b1);
        add_pop();
        add_edge(1'b0, gen_ms + 32'd100);
        add_edge(1'b1, gen_ms + 32'd100);
        levels = frame_levels(8'hFF);
        for (int i = 0; i < 11; i++)
            add_edge(levels[i], 32'hFFFFFFF8 + i);
        add_pop();
        add_pop();

        // Random phases, each under a new gap limit and idling pattern
        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            repeat (4) @(negedge clk);
            write_gap_limit(limits[p]);
            set_idling(idle_mode_t'(p % 4));
            fill_random(counts[p], pops[p]);
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && report_q.size() == 0)
            $display("ps2_frame_receiver_fifo: match");
        else
            $display("ps2_frame_receiver_fifo: mismatch");
        $finish;
    end

endmodule

### ps2_frame_receiver_fifo.f
sv/ps2fr_pkg.sv
sv/ps2fr_frame.sv
sv/ps2fr_ring.sv
sv/ps2fr_ps2_frame_receiver_fifo.sv
sv/ps2_frame_receiver_fifo.sv
sim/ps2_frame_receiver_fifo_tb.sv
